### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;
    localparam int OUT_TDATA_W   = 40;
    localparam int CFG_ADDR_W    = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 1'b1;

    localparam logic [FIELD_BITS-1:0] EXPONENT_RST = 32'd17;
    localparam logic [FIELD_BITS-1:0] MODULUS_RST  = 32'd3233;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_OUT
    } mexp_state_t;

endpackage

### rtl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// The base is first reduced modulo the modulus; then each exponent bit gets a
// square and each set bit a further multiply, all by shift-add steps; the
// result is then loaded into the output register that drives m_tvalid.
// A modulus below 2 goes straight to the output with bad_modulus set.
// One base is worked on at a time, so no new item is taken while busy:
// s_tready stays low until the result is loaded, and a stalled output holds it.
// Reset: aresetn synchronous active low; exponent 17, modulus 3233, idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [mexp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [mexp_pkg::FIELD_BITS-1:0]        cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mexp_pkg::FIELD_BITS-1:0]        s_tdata,  // [31:0] base_value
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mexp_pkg::OUT_TDATA_W-1:0]       m_tdata   // [31:0] power_result,
                                                             // [32] bad_modulus, rest 0
);
    import mexp_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

    mexp_state_t state_reg, state_next;

    logic [FIELD_BITS-1:0] cfg_exp_reg, cfg_mod_reg;
    logic [W-1:0]  exp_reg, exp_next;
    logic [W-1:0]  mod_reg, mod_next;
    logic [W-1:0]  base_reg, base_next;
    logic [W-1:0]  prod_reg, prod_next;
    logic [W-1:0]  opa_reg, opa_next;
    logic [W-1:0]  opb_reg, opb_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ebit_reg, ebit_next;
    logic [W-1:0]  res_reg, res_next;
    logic          bad_reg, bad_next;
    logic [FIELD_BITS-1:0] out_res_reg, out_res_next;
    logic          out_bad_reg, out_bad_next;
    logic          m_tvalid_reg, m_tvalid_next;

    logic [W-1:0]  cfg_exp_w, cfg_mod_w;
    logic [W:0]    dbl_sum, add_sum, mod_ext;
    logic [W-1:0]  dbl_mod, add_mod, step;
    logic          in_acc, mul_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_exp_reg <= EXPONENT_RST;
            cfg_mod_reg <= MODULUS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_EXPONENT: cfg_exp_reg <= cfg_wdata;
                REG_MODULUS:  cfg_mod_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg_exp_w = W'(cfg_exp_reg);
    assign cfg_mod_w = W'(cfg_mod_reg);

    // shift-add modular multiply step: acc = 2*acc (+ a) mod m
    assign mod_ext = {1'b0, mod_reg};
    assign dbl_sum = {1'b0, prod_reg} + {1'b0, prod_reg};
    assign dbl_mod = (dbl_sum >= mod_ext) ? W'(dbl_sum - mod_ext) : W'(dbl_sum);
    assign add_sum = {1'b0, dbl_mod} + {1'b0, opa_reg};
    assign add_mod = (add_sum >= mod_ext) ? W'(add_sum - mod_ext) : W'(add_sum);
    assign step    = opb_reg[cnt_reg] ? add_mod : dbl_mod;
    assign mul_last = (cnt_reg == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        exp_next      = exp_reg;
        mod_next      = mod_reg;
        base_next     = base_reg;
        prod_next     = prod_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        cnt_next      = cnt_reg;
        ebit_next     = ebit_reg;
        res_next      = res_reg;
        bad_next      = bad_reg;
        out_res_next  = out_res_reg;
        out_bad_next  = out_bad_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    exp_next  = cfg_exp_w;
                    mod_next  = cfg_mod_w;
                    prod_next = '0;
                    opa_next  = W'(1);
                    opb_next  = W'(s_tdata);
                    cnt_next  = LAST_BIT;
                    if (cfg_mod_w < W'(2)) begin
                        res_next   = '0;
                        bad_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        bad_next   = 1'b0;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                prod_next = step;
                cnt_next  = cnt_reg - CW'(1);
                if (mul_last) begin
                    base_next  = step;
                    prod_next  = '0;
                    opa_next   = W'(1);
                    opb_next   = W'(1);
                    cnt_next   = LAST_BIT;
                    ebit_next  = LAST_BIT;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE, ST_MULT: begin
                prod_next = step;
                cnt_next  = cnt_reg - CW'(1);
                if (mul_last) begin
                    prod_next = '0;
                    cnt_next  = LAST_BIT;
                    if (state_reg == ST_SQUARE && exp_reg[ebit_reg]) begin
                        opa_next   = step;
                        opb_next   = base_reg;
                        state_next = ST_MULT;
                    end else if (ebit_reg == '0) begin
                        res_next   = step;
                        state_next = ST_OUT;
                    end else begin
                        opa_next   = step;
                        opb_next   = step;
                        ebit_next  = ebit_reg - CW'(1);
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_res_next  = FIELD_BITS'(res_reg);
                    out_bad_next  = bad_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg     <= exp_next;
        mod_reg     <= mod_next;
        base_reg    <= base_next;
        prod_reg    <= prod_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        cnt_reg     <= cnt_next;
        ebit_reg    <= ebit_next;
        res_reg     <= res_next;
        bad_reg     <= bad_next;
        out_res_reg <= out_res_next;
        out_bad_reg <= out_bad_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - FIELD_BITS - 1){1'b0}}, out_bad_reg, out_res_reg};

`ifndef SYNTHESIS
    a_prod_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REDUCE || state_reg == ST_SQUARE || state_reg == ST_MULT)
        |-> (prod_reg < mod_reg && opa_reg < mod_reg))
        else $error("accumulator or operand not reduced");

    a_bad_goes_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && cfg_mod_w < W'(2)) |=> (state_reg == ST_OUT && bad_reg))
        else $error("bad modulus did not skip the multiply");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[FIELD_BITS]) |-> (m_tdata[FIELD_BITS-1:0] == '0))
        else $error("bad modulus with nonzero result");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("finished item not presented");
`endif

endmodule

### tb/tb_modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_top
// Self-checking bench for the modular exponentiation block: loads exponent
// and modulus pairs through the write port, streams base numbers in, and
// compares each power/flag item against a square-and-multiply predictor.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_top;
    import mexp_pkg::*;

    class power_mod_book;
        typedef struct packed {
            logic [FIELD_BITS-1:0] power;
            logic                  bad;
        } power_expect_t;

        logic [FIELD_BITS-1:0] exp_reg;
        logic [FIELD_BITS-1:0] mod_reg;
        power_expect_t         awaited_powers[$];
        int                    errors;
        int                    checked;
        int                    bad_seen;
        int                    bases;

        function new();
            exp_reg  = EXPONENT_RST;
            mod_reg  = MODULUS_RST;
            errors   = 0;
            checked  = 0;
            bad_seen = 0;
            bases    = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [FIELD_BITS-1:0] v);
            if (idx == REG_EXPONENT) begin
                exp_reg = v;
            end else if (idx == REG_MODULUS) begin
                mod_reg = v;
            end
        endfunction

        function void note_base(logic [FIELD_BITS-1:0] base_value);
            logic [63:0]   m64;
            logic [63:0]   b64;
            logic [63:0]   acc;
            power_expect_t want;
            bases++;
            m64 = {32'd0, mod_reg};
            if (m64 < 2) begin
                want.power = '0;
                want.bad   = 1'b1;
            end else begin
                b64 = {32'd0, base_value} % m64;
                acc = 64'd1;
                for (int i = FIELD_BITS - 1; i >= 0; i--) begin
                    acc = (acc * acc) % m64;
                    if (exp_reg[i]) begin
                        acc = (acc * b64) % m64;
                    end
                end
                want.power = acc[FIELD_BITS-1:0];
                want.bad   = 1'b0;
            end
            awaited_powers.push_back(want);
        endfunction

        function void check_power(logic [OUT_TDATA_W-1:0] word);
            power_expect_t want;
            if (awaited_powers.size() == 0) begin
                errors++;
                $display("%0t: result with none pending: expected none, actual %h", $time, word);
                return;
            end
            want = awaited_powers.pop_front();
            checked++;
            if (want.bad) begin
                bad_seen++;
            end
            if (word[FIELD_BITS-1:0] !== want.power) begin
                errors++;
                $display("%0t: power_result mismatch: expected %h, actual %h",
                         $time, want.power, word[FIELD_BITS-1:0]);
            end
            if (word[FIELD_BITS] !== want.bad) begin
                errors++;
                $display("%0t: bad_modulus mismatch: expected %b, actual %b",
                         $time, want.bad, word[FIELD_BITS]);
            end
            if (word[OUT_TDATA_W-1:FIELD_BITS+1] !== '0) begin
                errors++;
                $display("%0t: pad bits mismatch: expected 0, actual %h",
                         $time, word[OUT_TDATA_W-1:FIELD_BITS+1]);
            end
        endfunction

        function int pending();
            return awaited_powers.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [FIELD_BITS-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [FIELD_BITS-1:0]  s_tdata;   // [31:0] base_value
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [31:0] power_result, [32] bad_modulus, rest 0

    power_mod_book powers;
    bit            steady_flow = 1'b0;
    int            key_loads   = 0;

    modular_exponentiation_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    task automatic load_key(input logic [FIELD_BITS-1:0] exp_v, input logic [FIELD_BITS-1:0] mod_v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_EXPONENT;
        cfg_wdata <= exp_v;
        @(posedge aclk);
        powers.set_register(REG_EXPONENT, exp_v);
        cfg_addr  <= REG_MODULUS;
        cfg_wdata <= mod_v;
        @(posedge aclk);
        powers.set_register(REG_MODULUS, mod_v);
        cfg_wr_en <= 1'b0;
        key_loads++;
    endtask

    task automatic push_base(input logic [FIELD_BITS-1:0] base_value);
        s_tvalid <= 1'b1;
        s_tdata  <= base_value;
        do @(posedge aclk); while (!s_tready);
        powers.note_base(base_value);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic drain_powers();
        s_tvalid <= 1'b0;
        while (powers.pending() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            powers.check_power(m_tdata);
        end
    end

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            if (steady_flow) begin
                @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                if (!steady_flow) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_modular_exponentiation_top: FAIL");
        $finish;
    end

    initial begin
        logic [FIELD_BITS-1:0] key_exp;
        logic [FIELD_BITS-1:0] key_mod;
        logic [FIELD_BITS-1:0] pick;
        powers    = new();
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_EXPONENT;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset key: exponent 17, modulus 3233
        push_base(32'd0);
        push_base(32'd1);
        push_base(32'd65);
        push_base(32'd3232);
        push_base(32'd3233);
        push_base(32'hFFFF_FFFF);
        drain_powers();

        load_key(32'd2753, 32'd3233);
        push_base(32'd2790);
        push_base(32'd0);
        drain_powers();

        load_key(32'd0, 32'd3233);
        push_base(32'd0);
        push_base(32'd7);
        push_base(32'hFFFF_FFFF);
        drain_powers();

        load_key(32'hFFFF_FFFF, 32'd0);
        push_base(32'hA5A5_A5A5);
        push_base(32'd0);
        drain_powers();

        load_key(32'h5A5A_5A5A, 32'd1);
        push_base(32'hFFFF_FFFF);
        push_base(32'd1);
        drain_powers();

        load_key(32'hFFFF_FFFF, 32'd2);
        push_base(32'd0);
        push_base(32'd1);
        push_base(32'd3);
        drain_powers();

        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_base(32'hFFFF_FFFE);
        push_base(32'hFFFF_FFFF);
        push_base(32'd2);
        push_base(32'h8000_0000);
        drain_powers();

        load_key(32'd1, 32'h8000_0000);
        push_base(32'h7FFF_FFFF);
        push_base(32'hFFFF_FFFF);
        drain_powers();

        for (int p = 0; p < 14; p++) begin
            steady_flow = (p >= 11);
            case ($urandom_range(0, 9))
                0:       key_mod = $urandom_range(0, 1);
                1, 2:    key_mod = $urandom_range(2, 65535);
                3:       key_mod = 32'hFFFF_FFFF - $urandom_range(0, 3);
                4, 5:    key_mod = $urandom | 32'h8000_0000;
                default: key_mod = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       key_exp = $urandom_range(0, 3);
                1:       key_exp = 32'd65537;
                2:       key_exp = 32'hFFFF_FFFF;
                default: key_exp = $urandom;
            endcase
            load_key(key_exp, key_mod);
            repeat (20) begin
                case ($urandom_range(0, 7))
                    0:       pick = key_mod - 32'd1;
                    1:       pick = key_mod;
                    2:       pick = $urandom_range(0, 3);
                    3:       pick = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: pick = $urandom;
                endcase
                push_base(pick);
            end
            drain_powers();
        end

        repeat (2200) @(posedge aclk);
        $display("Streamed %0d base items across %0d key loads plus the reset key.",
                 powers.bases, key_loads);
        $display("Checked %0d results, %0d of them flagged for a modulus below 2.",
                 powers.checked, powers.bad_seen);
        if (powers.errors == 0) begin
            $display("tb_modular_exponentiation_top: PASS");
        end else begin
            $display("tb_modular_exponentiation_top: FAIL");
        end
        $finish;
    end
endmodule
